// ===== hdl/gtq_pkg.sv =====
// package for the grouped team queue
// holds sizes, codes and the transaction structs shared by grouped_team_queue and gtq_order
`timescale 1ns / 1ps

package gtq_pkg;

    localparam int ELEMENTS = 4096;
    localparam int TEAMS    = 1024;

    localparam int ELEM_W = 12;
    localparam int TEAM_W = 10;

    localparam int ELEM_AW   = $clog2(ELEMENTS);
    localparam int TEAM_AW   = $clog2(TEAMS);
    localparam int CNT_W     = TEAM_AW + 1;
    localparam int CLR_DEPTH = (ELEMENTS > TEAMS) ? ELEMENTS : TEAMS;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    typedef enum logic [1:0] {
        F_ASSIGN  = 2'd0,
        F_ENQUEUE = 2'd1,
        F_DEQUEUE = 2'd2,
        F_CLEAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DUP   = 2'd2
    } t_status;

    typedef struct packed {
        t_func              func;
        logic [ELEM_W-1:0]  element;
        logic [TEAM_W-1:0]  team;
    } t_cmd;

    typedef struct packed {
        logic               has_value;
        logic [ELEM_W-1:0]  value;
        t_status            status;
    } t_result;

    typedef struct packed {
        logic               present;
        logic [ELEM_AW-1:0] first;
        logic [ELEM_AW-1:0] last;
    } t_team_rec;

    typedef struct packed {
        logic               clear;
        logic               push;
        logic               pop;
        logic [TEAM_AW-1:0] push_team;
    } t_ord_ctl;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [TEAM_AW-1:0] front_team;
    } t_ord_sts;

endpackage

// ===== hdl/grouped_team_queue.sv =====
// grouped team queue top level: command sequencer and element/team memories
// uses gtq_pkg, gtq_ram and gtq_order
`timescale 1ns / 1ps

// usage
// a transaction is taken on a rising edge with start high and busy low;
// i_cmd carries func, element and team. every transaction gives exactly one
// result on o_result, valid for the single cycle in which o_strobe is high,
// and o_strobe always falls in a cycle where busy is low.
// steps from acceptance to the strobe cycle, which is also the earliest
// cycle the next transaction can be taken:
//   assign, out-of-range enqueue, dequeue on empty queue: answered without a memory read
//   enqueue of an element already queued: element memory read
//   enqueue: element memory read, team memory read, write back
//   dequeue: order read, team read, link read, write back
//   clear: one element slot per cycle to clear queued flags and team records
// every step waits on the registered read of the rams, so one
// transaction is in flight at a time.
// after reset busy stays high while the member, queued and team memories are
// swept to zero; no result comes from that sweep. the receiver cannot stall:
// results are never held.
module grouped_team_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  gtq_pkg::t_cmd    i_cmd,
    output logic             busy,
    output logic             o_strobe,
    output gtq_pkg::t_result o_result
);

    import gtq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,
        S_ENQ_A = 6'b000100,
        S_ENQ_T = 6'b001000,
        S_DEQ_O = 6'b010000,
        S_DEQ_T = 6'b100000
    } t_state;

    // dequeue link stage shares the team-write path, kept as its own flag
    t_state             r_state, n_state;
    logic               r_deq_l, n_deq_l;
    t_cmd               r_cmd, n_cmd;
    logic [TEAM_AW-1:0] r_team, n_team;
    t_team_rec          r_trec, n_trec;
    logic [CLR_AW-1:0]  r_cnt, n_cnt;
    logic               r_rst_sweep, n_rst_sweep;
    logic               r_strobe, n_strobe;
    t_result            r_result, n_result;

    logic               a_we;
    logic [ELEM_AW-1:0] a_waddr;
    logic [TEAM_AW-1:0] a_wdata;
    logic [TEAM_AW-1:0] a_rdata;

    logic               q_we;
    logic [ELEM_AW-1:0] q_waddr;
    logic               q_wdata;
    logic               q_rdata;

    logic               l_we;
    logic [ELEM_AW-1:0] l_waddr;
    logic [ELEM_AW-1:0] l_wdata;
    logic [ELEM_AW-1:0] l_raddr;
    logic [ELEM_AW-1:0] l_rdata;

    logic               t_we;
    logic [TEAM_AW-1:0] t_waddr;
    t_team_rec          t_wdata;
    logic [TEAM_AW-1:0] t_raddr;
    t_team_rec          t_rdata;

    logic [ELEM_AW-1:0] in_elem;
    logic               accept;
    logic               in_elem_ok;
    logic               in_team_ok;
    logic [ELEM_AW-1:0] cur_elem;

    t_ord_ctl           ord_ctl;
    t_ord_sts           ord_sts;

    assign accept     = start && (r_state == S_IDLE) && !r_deq_l;
    assign in_elem    = ELEM_AW'(i_cmd.element);
    assign in_elem_ok = (32'(i_cmd.element) < 32'(ELEMENTS));
    assign in_team_ok = (32'(i_cmd.team) < 32'(TEAMS));
    assign cur_elem   = ELEM_AW'(r_cmd.element);

    gtq_ram #(.WIDTH (TEAM_AW), .DEPTH (ELEMENTS)) u_member (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (in_elem),
        .o_rdata (a_rdata)
    );

    gtq_ram #(.WIDTH (1), .DEPTH (ELEMENTS)) u_queued (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (in_elem),
        .o_rdata (q_rdata)
    );

    gtq_ram #(.WIDTH (ELEM_AW), .DEPTH (ELEMENTS)) u_link (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    gtq_ram #(.WIDTH ($bits(t_team_rec)), .DEPTH (TEAMS)) u_team (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    gtq_order u_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ord_ctl),
        .o_sts   (ord_sts)
    );

    always_comb begin
        n_state     = r_state;
        n_deq_l     = 1'b0;
        n_cmd       = r_cmd;
        n_team      = r_team;
        n_trec      = r_trec;
        n_cnt       = r_cnt;
        n_rst_sweep = r_rst_sweep;
        n_strobe    = 1'b0;
        n_result    = '{has_value: 1'b0, value: '0, status: ST_OK};

        a_we    = 1'b0;
        a_waddr = in_elem;
        a_wdata = TEAM_AW'(i_cmd.team);
        q_we    = 1'b0;
        q_waddr = cur_elem;
        q_wdata = 1'b0;
        l_we    = 1'b0;
        l_waddr = t_rdata.last;
        l_wdata = cur_elem;
        l_raddr = t_rdata.first;
        t_we    = 1'b0;
        t_waddr = r_team;
        t_wdata = t_rdata;
        t_raddr = r_team;
        ord_ctl = '{clear: 1'b0, push: 1'b0, pop: 1'b0, push_team: r_team};

        if (r_deq_l) begin
            // link of the dequeued element is back; retire or advance the team
            n_strobe       = 1'b1;
            n_result.has_value = 1'b1;
            n_result.value = ELEM_W'(r_trec.first);
            t_we           = 1'b1;
            if (r_trec.first == r_trec.last) begin
                t_wdata     = r_trec;
                t_wdata.present = 1'b0;
                ord_ctl.pop = 1'b1;
            end else begin
                t_wdata       = r_trec;
                t_wdata.first = l_rdata;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        n_cmd = i_cmd;
                        case (i_cmd.func)
                            F_ASSIGN: begin
                                a_we     = in_elem_ok && in_team_ok;
                                n_strobe = 1'b1;
                            end
                            F_ENQUEUE: begin
                                if (in_elem_ok) begin
                                    n_state = S_ENQ_A;
                                end else begin
                                    n_strobe = 1'b1;
                                end
                            end
                            F_DEQUEUE: begin
                                if (ord_sts.empty) begin
                                    n_strobe        = 1'b1;
                                    n_result.status = ST_EMPTY;
                                end else begin
                                    n_state = S_DEQ_O;
                                end
                            end
                            F_CLEAR: begin
                                ord_ctl.clear = 1'b1;
                                n_state       = S_SWEEP;
                                n_cnt         = '0;
                                n_rst_sweep   = 1'b0;
                            end
                            default: begin
                                n_strobe = 1'b1;
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    a_we    = r_rst_sweep && (32'(r_cnt) < 32'(ELEMENTS));
                    a_waddr = ELEM_AW'(r_cnt);
                    a_wdata = '0;
                    q_we    = (32'(r_cnt) < 32'(ELEMENTS));
                    q_waddr = ELEM_AW'(r_cnt);
                    q_wdata = 1'b0;
                    t_we    = (32'(r_cnt) < 32'(TEAMS));
                    t_waddr = TEAM_AW'(r_cnt);
                    t_wdata = '0;
                    n_cnt   = r_cnt + 1'b1;
                    if (r_cnt == CLR_AW'(CLR_DEPTH - 1)) begin
                        n_state  = S_IDLE;
                        n_strobe = !r_rst_sweep;
                    end
                end
                S_ENQ_A: begin
                    t_raddr = a_rdata;
                    n_team  = a_rdata;
                    if (q_rdata) begin
                        n_state         = S_IDLE;
                        n_strobe        = 1'b1;
                        n_result.status = ST_DUP;
                    end else begin
                        n_state = S_ENQ_T;
                    end
                end
                S_ENQ_T: begin
                    q_we    = 1'b1;
                    q_waddr = cur_elem;
                    q_wdata = 1'b1;
                    t_we    = 1'b1;
                    if (!t_rdata.present) begin
                        t_wdata = '{present: 1'b1, first: cur_elem, last: cur_elem};
                        ord_ctl.push = !ord_sts.full;
                    end else begin
                        l_we         = 1'b1;
                        t_wdata      = t_rdata;
                        t_wdata.last = cur_elem;
                    end
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                end
                S_DEQ_O: begin
                    t_raddr = ord_sts.front_team;
                    n_team  = ord_sts.front_team;
                    n_state = S_DEQ_T;
                end
                S_DEQ_T: begin
                    n_trec  = t_rdata;
                    q_we    = 1'b1;
                    q_waddr = t_rdata.first;
                    q_wdata = 1'b0;
                    l_raddr = t_rdata.first;
                    n_state = S_IDLE;
                    n_deq_l = 1'b1;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_deq_l     <= 1'b0;
            r_cnt       <= '0;
            r_rst_sweep <= 1'b1;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_deq_l     <= n_deq_l;
            r_cnt       <= n_cnt;
            r_rst_sweep <= n_rst_sweep;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_team   <= n_team;
        r_trec   <= n_trec;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE) || r_deq_l;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while a transaction is in flight");
    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.has_value) |-> (o_result.status == ST_OK))
        else $error("dequeued value with error status");
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted transaction neither busy nor answered");
    a_order_pop_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ord_ctl.pop |-> r_deq_l)
        else $error("team order popped outside a dequeue");
`endif

endmodule

// ===== hdl/gtq_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module gtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gtq_order.sv =====
// circular order of teams that have queued members
// uses gtq_pkg and one gtq_ram for the team slots
`timescale 1ns / 1ps

module gtq_order (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gtq_pkg::t_ord_ctl i_ctl,
    output gtq_pkg::t_ord_sts o_sts
);

    import gtq_pkg::*;

    logic [TEAM_AW-1:0] r_rp;
    logic [TEAM_AW-1:0] r_wp;
    logic [CNT_W-1:0]   r_count;
    logic [TEAM_AW-1:0] n_rp;
    logic [TEAM_AW-1:0] n_wp;
    logic [CNT_W-1:0]   n_count;
    logic [TEAM_AW-1:0] front;

    gtq_ram #(
        .WIDTH (TEAM_AW),
        .DEPTH (TEAMS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_wp),
        .i_wdata (i_ctl.push_team),
        .i_raddr (r_rp),
        .o_rdata (front)
    );

    always_comb begin
        n_rp    = r_rp;
        n_wp    = r_wp;
        n_count = r_count;
        if (i_ctl.clear) begin
            n_rp    = '0;
            n_wp    = '0;
            n_count = '0;
        end else if (i_ctl.push) begin
            n_wp    = (r_wp == TEAM_AW'(TEAMS - 1)) ? '0 : r_wp + 1'b1;
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_rp    = (r_rp == TEAM_AW'(TEAMS - 1)) ? '0 : r_rp + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_count <= '0;
        end else begin
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_count <= n_count;
        end
    end

    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = (r_count == CNT_W'(TEAMS));
    assign o_sts.front_team = front;

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_sts.full)
        else $error("team order push while full");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_sts.empty)
        else $error("team order pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TEAMS))
        else $error("team order count beyond capacity");
`endif

endmodule

// ===== bench/grouped_team_queue_tb.sv =====
// self-checking testbench for grouped_team_queue: a directed table, then random transactions
// predicts the results of non-fixed rows with its own copy of the team queue; uses gtq_pkg and grouped_team_queue
`timescale 1ns / 1ps

module grouped_team_queue_tb;
    import gtq_pkg::*;

    localparam int RAND_ITEMS   = 1025;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;

    localparam t_result R_OK    = '{1'b0, 12'd0, ST_OK};
    localparam t_result R_EMPTY = '{1'b0, 12'd0, ST_EMPTY};
    localparam t_result R_DUP   = '{1'b0, 12'd0, ST_DUP};

    typedef struct packed {
        t_cmd    cmd;
        logic    fixed;
        t_result res;
    } t_row;

    localparam int N_ROWS = 25;

    // rows with fixed set carry their result; the rest go through the predictor
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{'{F_DEQUEUE, 12'd0,    10'd0},    1'b1, R_EMPTY},
        '{'{F_ENQUEUE, 12'd4095, 10'd0},    1'b1, R_OK},
        '{'{F_ENQUEUE, 12'd4095, 10'd0},    1'b1, R_DUP},
        '{'{F_ASSIGN,  12'd0,    10'd1023}, 1'b1, R_OK},
        '{'{F_ASSIGN,  12'd4095, 10'd1023}, 1'b1, R_OK},
        '{'{F_ENQUEUE, 12'd0,    10'd0},    1'b1, R_OK},
        '{'{F_ENQUEUE, 12'd1,    10'd1023}, 1'b0, R_OK},
        '{'{F_ASSIGN,  12'd2,    10'd1023}, 1'b0, R_OK},
        '{'{F_ENQUEUE, 12'd2,    10'd0},    1'b0, R_OK},
        '{'{F_ENQUEUE, 12'd3,    10'd682},  1'b0, R_OK},
        '{'{F_DEQUEUE, 12'd4095, 10'd1023}, 1'b0, R_OK},
        '{'{F_DEQUEUE, 12'd0,    10'd0},    1'b0, R_OK},
        '{'{F_DEQUEUE, 12'd0,    10'd0},    1'b0, R_OK},
        '{'{F_DEQUEUE, 12'd0,    10'd0},    1'b0, R_OK},
        '{'{F_DEQUEUE, 12'd0,    10'd0},    1'b0, R_OK},
        '{'{F_DEQUEUE, 12'd0,    10'd0},    1'b1, R_EMPTY},
        '{'{F_ENQUEUE, 12'd4095, 10'd0},    1'b0, R_OK},
        '{'{F_ENQUEUE, 12'd1,    10'd341},  1'b0, R_OK},
        '{'{F_CLEAR,   12'd4095, 10'd1023}, 1'b1, R_OK},
        '{'{F_DEQUEUE, 12'd0,    10'd0},    1'b1, R_EMPTY},
        '{'{F_ENQUEUE, 12'd4095, 10'd0},    1'b0, R_OK},
        '{'{F_DEQUEUE, 12'd0,    10'd0},    1'b0, R_OK},
        '{'{F_ASSIGN,  12'd4095, 10'd0},    1'b0, R_OK},
        '{'{F_ASSIGN,  12'd2730, 10'd341},  1'b0, R_OK},
        '{'{F_ASSIGN,  12'd1365, 10'd682},  1'b0, R_OK}
    };

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // predicted queue state
    bit [TEAM_W-1:0]  elem_team     [ELEMENTS];
    bit [ELEM_W-1:0]  elem_next     [ELEMENTS];
    bit               elem_queued   [ELEMENTS];
    bit [ELEM_W-1:0]  team_head     [TEAMS];
    bit [ELEM_W-1:0]  team_tail     [TEAMS];
    bit               team_in_order [TEAMS];
    bit [TEAM_W-1:0]  order_ring    [TEAMS];
    bit [TEAM_AW-1:0] ring_rd;
    bit [TEAM_AW-1:0] ring_wr;
    int               ring_count;

    t_result pending_results [$];
    int      n_sent;
    int      n_taken;
    int      n_errors;
    int      cycles;
    bit      row_fixed;
    t_result row_res;

    grouped_team_queue DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_team_queue(input t_cmd c, output t_result r);
        bit [TEAM_W-1:0] t;
        bit [ELEM_W-1:0] e;
        r = R_OK;
        case (c.func)
            F_ASSIGN: begin
                elem_team[c.element] = c.team;
            end
            F_ENQUEUE: begin
                e = c.element;
                if (elem_queued[e]) begin
                    r.status = ST_DUP;
                end else begin
                    t = elem_team[e];
                    if (!team_in_order[t]) begin
                        team_head[t] = e;
                        team_tail[t] = e;
                        team_in_order[t] = 1'b1;
                        if (ring_count < TEAMS) begin
                            order_ring[ring_wr] = t;
                            ring_wr = ring_wr + 1'b1;
                            ring_count++;
                        end
                    end else begin
                        elem_next[team_tail[t]] = e;
                        team_tail[t] = e;
                    end
                    elem_queued[e] = 1'b1;
                end
            end
            F_DEQUEUE: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    t = order_ring[ring_rd];
                    e = team_head[t];
                    elem_queued[e] = 1'b0;
                    if (e == team_tail[t]) begin
                        team_in_order[t] = 1'b0;
                        ring_rd = ring_rd + 1'b1;
                        ring_count--;
                    end else begin
                        team_head[t] = elem_next[e];
                    end
                    r.has_value = 1'b1;
                    r.value = e;
                end
            end
            default: begin
                foreach (elem_queued[i]) elem_queued[i] = 1'b0;
                foreach (team_in_order[i]) team_in_order[i] = 1'b0;
                ring_rd = '0;
                ring_wr = '0;
                ring_count = 0;
            end
        endcase
    endtask

    // accept transactions and check results, both sampled at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        t_result guess;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: result with none pending, expected none, actual %0d/%0d/%0d",
                             $time, o_result.has_value, o_result.value, o_result.status);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.has_value !== want.has_value) begin
                        n_errors++;
                        $display("%0t: has_value mismatch, expected %0d, actual %0d",
                                 $time, want.has_value, o_result.has_value);
                    end
                    if (o_result.value !== want.value) begin
                        n_errors++;
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, want.value, o_result.value);
                    end
                    if (o_result.status !== want.status) begin
                        n_errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, o_result.status);
                    end
                end
            end
            if (start && !busy) begin
                predict_team_queue(i_cmd, guess);
                pending_results.insert(pending_results.size(), row_fixed ? row_res : guess);
                n_taken++;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("grouped_team_queue_tb: FAIL");
        $finish;
    end

    task automatic send_cmd(input t_cmd c, input bit fixed, input t_result fixed_res,
                            input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        row_fixed = fixed;
        row_res = fixed_res;
        n_sent++;
        wait (n_taken == n_sent);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_results.size() == 0);
    endtask

    // mode 0 fills the queue, mode 1 drains it, mode 2 is balanced
    function automatic t_cmd random_cmd(int mode);
        t_cmd c;
        int   pick;
        int   enq_pct;
        int   deq_pct;
        int   r;
        enq_pct = (mode == 0) ? 60 : (mode == 1) ? 15 : 40;
        deq_pct = (mode == 0) ? 20 : (mode == 1) ? 65 : 40;
        r = $urandom_range(0, 99);
        if (r < 80) c.element = ELEM_W'($urandom_range(0, 39));
        else if (r < 92) c.element = ELEM_W'($urandom_range(0, 4095));
        else c.element = ELEM_W'($urandom_range(4032, 4095));
        r = $urandom_range(0, 99);
        if (r < 75) c.team = TEAM_W'($urandom_range(0, 4));
        else if (r < 90) c.team = TEAM_W'($urandom_range(1018, 1023));
        else c.team = TEAM_W'($urandom_range(0, 1023));
        pick = $urandom_range(0, 999);
        if (pick < 12) c.func = F_CLEAR;
        else if (pick < 12 + enq_pct * 10) c.func = F_ENQUEUE;
        else if (pick < 12 + (enq_pct + deq_pct) * 10) c.func = F_DEQUEUE;
        else c.func = F_ASSIGN;
        return c;
    endfunction

    initial begin
        int n_rand;
        int blk;
        int len;
        int k;
        int mode;
        bit idle_on;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        row_fixed = 1'b0;
        row_res = R_OK;
        n_sent = 0;
        n_taken = 0;
        n_errors = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].res, 1'b1);
        wait_drained();

        n_rand = 0;
        blk = 0;
        while (n_rand < RAND_ITEMS) begin
            mode = $urandom_range(0, 2);
            idle_on = ($urandom_range(0, 2) != 0);
            len = $urandom_range(20, 60);
            for (k = 0; k < len && n_rand < RAND_ITEMS; k++) begin
                send_cmd(random_cmd(mode), 1'b0, R_OK,
                         idle_on && (n_rand < RAND_ITEMS - QUIET_TAIL));
                n_rand++;
            end
            blk++;
            if (blk == 6) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("grouped_team_queue_tb: PASS");
        end else begin
            $display("grouped_team_queue_tb: FAIL");
        end
        $finish;
    end

endmodule
